### hdl/pidta_pkg.sv
// ----------------------------------------------------------------------------
// pidta_pkg
// Shared types and constants for the trapezoidal PID controller.
// ----------------------------------------------------------------------------
package pidta_pkg;

	localparam int INTEG_BITS_DEF = 48;

	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 36;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = 66;
	localparam int ACC_W   = 46;
	localparam int PACC_W  = 80;
	localparam int BACK_W  = 56;
	localparam int DIV_W   = 33;
	localparam int DEN_W   = 16;

	typedef enum logic [2:0] {
		REG_GAIN_PROP  = 3'd0,
		REG_GAIN_INT   = 3'd1,
		REG_GAIN_DERIV = 3'd2,
		REG_TARGET     = 3'd3,
		REG_OUT_MAX    = 3'd4,
		REG_OUT_MIN    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		WIND_NONE = 2'd0,
		WIND_HIGH = 2'd1,
		WIND_LOW  = 2'd2
	} windup_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRAP,
		ST_MUL_P,
		ST_MUL_ED,
		ST_DIV_GO,
		ST_DIV,
		ST_MUL_GD,
		ST_MUL_ILO,
		ST_MUL_IHI,
		ST_MUL_DDT,
		ST_MUL_DDT2,
		ST_BACK,
		ST_FIN
	} state_t;

endpackage

### hdl/pidta_if.sv
// ----------------------------------------------------------------------------
// pidta channel interfaces
// Valid/ready channels for samples in and controller results out.
// ----------------------------------------------------------------------------
interface pidta_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] measured;
	logic        [15:0] elapsed;

	modport source (output valid, measured, elapsed, input ready);
	modport sink (input valid, measured, elapsed, output ready);
endinterface

interface pidta_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic        [1:0]  windup;

	modport source (output valid, drive, windup, input ready);
	modport sink (input valid, drive, windup, output ready);
endinterface

### hdl/pid_trapezoid_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_trapezoid_antiwindup
// PID controller with trapezoidal integral, derivative and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// A 33-step serial divider forms the derivative. One shared 18x36 multiplier
// is used eight times in turn, for the trapezoid, the three gain products and
// the back-calculation. The block takes no new sample until the result of the
// previous one has been loaded into the output register, so a stalled result
// also holds off the next sample.
// Configuration writes go to six 16-bit registers by index.
module pid_trapezoid_antiwindup #(
	parameter int INTEG_BITS = pidta_pkg::INTEG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_idx,
	input  logic [15:0] wr_data,
	pidta_in_if.sink    sample,
	pidta_out_if.source result
);
	localparam int WW = pidta_pkg::WIDE_W;
	localparam logic signed [WW-1:0] IMAX = (WW'(1) <<< (INTEG_BITS - 1)) - WW'(1);
	localparam logic signed [WW-1:0] IMIN = -IMAX - WW'(1);
	localparam logic signed [pidta_pkg::PACC_W-1:0] BIG = pidta_pkg::PACC_W'(1) <<< 51;
	localparam logic signed [pidta_pkg::ACC_W-1:0] CAP = pidta_pkg::ACC_W'(1) <<< 43;
	localparam logic signed [pidta_pkg::ACC_W-1:0] DMAX = pidta_pkg::ACC_W'(32'h7fffffff);
	localparam logic signed [pidta_pkg::ACC_W-1:0] DMIN = -DMAX - pidta_pkg::ACC_W'(1);

	function automatic logic signed [INTEG_BITS-1:0] clamp_i(input logic signed [WW-1:0] x);
		logic signed [WW-1:0] r;
		r = x;
		if (x > IMAX) r = IMAX;
		if (x < IMIN) r = IMIN;
		return INTEG_BITS'(r);
	endfunction

	logic signed [15:0] gain_prop_q, gain_int_q, gain_deriv_q, target_q, out_max_q, out_min_q;
	logic signed [16:0] e_q, prev_q;
	logic        [15:0] dt_q;
	logic signed [INTEG_BITS-1:0] integ_q;
	logic signed [33:0] deriv_q;
	logic signed [pidta_pkg::MUL_P_W-1:0] prod_q;
	logic signed [pidta_pkg::ACC_W-1:0]   acc_q;
	logic signed [pidta_pkg::BACK_W-1:0]  back_q;
	logic signed [pidta_pkg::PACC_W-1:0]  pacc_q;
	logic signed [31:0] drive_q;
	pidta_pkg::windup_t windup_q;
	logic               out_valid_q;
	pidta_pkg::state_t  state_q, state_d;

	logic signed [pidta_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pidta_pkg::MUL_B_W-1:0] mul_b;
	logic signed [17:0] sum_ep, diff_ep, mag_ep;
	logic               div_start, div_done, fin_go, in_xfer;
	logic [pidta_pkg::DIV_W-1:0] div_quo;
	logic signed [33:0] dq, deriv_n;
	logic signed [63:0] i64;
	logic               gti_big;
	logic signed [pidta_pkg::ACC_W-1:0] gti, hi_lim, lo_lim;
	logic               over, under;

	assign in_xfer = sample.valid && sample.ready;
	assign sample.ready = (state_q == pidta_pkg::ST_IDLE);
	assign fin_go = (state_q == pidta_pkg::ST_FIN) && (!out_valid_q || result.ready);
	assign div_start = (state_q == pidta_pkg::ST_DIV_GO);

	assign sum_ep  = 18'(e_q) + 18'(prev_q);
	assign diff_ep = 18'(e_q) - 18'(prev_q);
	assign mag_ep  = diff_ep[17] ? -diff_ep : diff_ep;
	assign dq      = $signed({1'b0, div_quo});
	assign deriv_n = diff_ep[17] ? -dq : dq;
	assign i64     = 64'(integ_q);

	assign gti_big = (pacc_q > BIG) || (pacc_q < -BIG);
	assign gti = gti_big ? (pacc_q[pidta_pkg::PACC_W-1] ? -CAP : CAP)
		: pidta_pkg::ACC_W'(pacc_q >>> 8);

	assign hi_lim = pidta_pkg::ACC_W'(out_max_q) <<< 16;
	assign lo_lim = pidta_pkg::ACC_W'(out_min_q) <<< 16;
	assign over   = acc_q > hi_lim;
	assign under  = acc_q < lo_lim;

	pidta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({mag_ep[16:0], 16'h0000}),
		.den    (dt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			pidta_pkg::ST_IDLE: begin
				if (in_xfer) state_d = pidta_pkg::ST_TRAP;
			end
			pidta_pkg::ST_TRAP: begin
				mul_a   = sum_ep;
				mul_b   = $signed({20'h0, dt_q});
				state_d = pidta_pkg::ST_MUL_P;
			end
			pidta_pkg::ST_MUL_P: begin
				mul_a   = 18'(gain_prop_q);
				mul_b   = 36'(e_q);
				state_d = pidta_pkg::ST_MUL_ED;
			end
			pidta_pkg::ST_MUL_ED: begin
				mul_a   = 18'(e_q);
				mul_b   = $signed({20'h0, dt_q});
				state_d = pidta_pkg::ST_DIV_GO;
			end
			pidta_pkg::ST_DIV_GO: state_d = pidta_pkg::ST_DIV;
			pidta_pkg::ST_DIV: begin
				if (div_done) state_d = pidta_pkg::ST_MUL_GD;
			end
			pidta_pkg::ST_MUL_GD: begin
				mul_a   = 18'(gain_deriv_q);
				mul_b   = 36'(deriv_q);
				state_d = pidta_pkg::ST_MUL_ILO;
			end
			pidta_pkg::ST_MUL_ILO: begin
				mul_a   = 18'(gain_int_q);
				mul_b   = $signed({4'h0, i64[31:0]});
				state_d = pidta_pkg::ST_MUL_IHI;
			end
			pidta_pkg::ST_MUL_IHI: begin
				mul_a   = 18'(gain_int_q);
				mul_b   = 36'($signed(i64[63:32]));
				state_d = pidta_pkg::ST_MUL_DDT;
			end
			pidta_pkg::ST_MUL_DDT: begin
				mul_a   = $signed({2'b00, dt_q});
				mul_b   = 36'(deriv_q);
				state_d = pidta_pkg::ST_MUL_DDT2;
			end
			pidta_pkg::ST_MUL_DDT2: begin
				mul_a   = $signed({2'b00, dt_q});
				mul_b   = prod_q[35:0];
				state_d = pidta_pkg::ST_BACK;
			end
			pidta_pkg::ST_BACK: state_d = pidta_pkg::ST_FIN;
			pidta_pkg::ST_FIN: begin
				if (fin_go) state_d = pidta_pkg::ST_IDLE;
			end
			default: state_d = pidta_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pidta_pkg::ST_IDLE;
			gain_prop_q  <= 16'sd256;
			gain_int_q   <= '0;
			gain_deriv_q <= '0;
			target_q     <= '0;
			out_max_q    <= 16'sh7fff;
			out_min_q    <= 16'sh8000;
			prev_q       <= '0;
			integ_q      <= '0;
			deriv_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (pidta_pkg::reg_idx_t'(wr_idx))
					pidta_pkg::REG_GAIN_PROP:  gain_prop_q  <= wr_data;
					pidta_pkg::REG_GAIN_INT:   gain_int_q   <= wr_data;
					pidta_pkg::REG_GAIN_DERIV: gain_deriv_q <= wr_data;
					pidta_pkg::REG_TARGET:     target_q     <= wr_data;
					pidta_pkg::REG_OUT_MAX:    out_max_q    <= wr_data;
					pidta_pkg::REG_OUT_MIN:    out_min_q    <= wr_data;
					default: ;
				endcase
			end
			if (state_q == pidta_pkg::ST_MUL_P)
				integ_q <= clamp_i(WW'(integ_q) + (WW'(prod_q) <<< 15));
			if (state_q == pidta_pkg::ST_DIV && div_done) begin
				deriv_q <= deriv_n;
				prev_q  <= e_q;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (over)
					integ_q <= clamp_i(WW'(hi_lim) - WW'(back_q));
				else if (under)
					integ_q <= clamp_i(WW'(lo_lim) + WW'(back_q));
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= pidta_pkg::MUL_P_W'(mul_a) * pidta_pkg::MUL_P_W'(mul_b);
		if (in_xfer) begin
			e_q  <= 17'(target_q) - 17'(sample.measured);
			dt_q <= (sample.elapsed == 16'h0000) ? 16'h0001 : sample.elapsed;
		end
		case (state_q)
			pidta_pkg::ST_MUL_ED:   acc_q  <= pidta_pkg::ACC_W'(prod_q) <<< 8;
			pidta_pkg::ST_DIV_GO:   back_q <= pidta_pkg::BACK_W'(prod_q) <<< 16;
			pidta_pkg::ST_MUL_ILO:  acc_q  <= acc_q + pidta_pkg::ACC_W'(prod_q >>> 8);
			pidta_pkg::ST_MUL_IHI:  pacc_q <= pidta_pkg::PACC_W'(prod_q);
			pidta_pkg::ST_MUL_DDT:  pacc_q <= pacc_q + (pidta_pkg::PACC_W'(prod_q) <<< 32);
			pidta_pkg::ST_MUL_DDT2: acc_q  <= acc_q + gti;
			pidta_pkg::ST_BACK:     back_q <= back_q + pidta_pkg::BACK_W'(prod_q);
			default: ;
		endcase
		if (fin_go) begin
			if (acc_q > DMAX)      drive_q <= 32'sh7fffffff;
			else if (acc_q < DMIN) drive_q <= 32'sh80000000;
			else                   drive_q <= acc_q[31:0];
			if (over)       windup_q <= pidta_pkg::WIND_HIGH;
			else if (under) windup_q <= pidta_pkg::WIND_LOW;
			else            windup_q <= pidta_pkg::WIND_NONE;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.drive  = drive_q;
	assign result.windup = windup_q;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !sample.ready)
		else $error("sample taken while busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pidta_pkg::ST_DIV)
		else $error("divider finished outside its wait state");

	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && state_q == pidta_pkg::ST_IDLE)
		else $error("result not presented after finish");
endmodule

### hdl/pidta_div.sv
// ----------------------------------------------------------------------------
// pidta_div
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module pidta_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pidta_pkg::DIV_W-1:0] num,
	input  logic [pidta_pkg::DEN_W-1:0] den,
	output logic                        done,
	output logic [pidta_pkg::DIV_W-1:0] quo
);
	localparam int CNT_W = $clog2(pidta_pkg::DIV_W + 1);

	logic [pidta_pkg::DIV_W-1:0] quo_q;
	logic [pidta_pkg::DEN_W-1:0] rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [pidta_pkg::DEN_W+1:0] diff;

	assign diff = {1'b0, rem_q, quo_q[pidta_pkg::DIV_W-1]} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pidta_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[pidta_pkg::DEN_W+1]) begin
				rem_q <= diff[pidta_pkg::DEN_W-1:0];
				quo_q <= {quo_q[pidta_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[pidta_pkg::DEN_W-2:0], quo_q[pidta_pkg::DIV_W-1]};
				quo_q <= {quo_q[pidta_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
